// ----- design/gis_pkg.sv -----
// Shared types and codes for the greedy independent set stream block.
`default_nettype none

package gis_pkg;

    // Width of the vertex ports, fixed by the interface
    localparam int VERTEX_PORT_BITS = 32;

    typedef enum logic [1:0] {
        STATUS_JOIN     = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_ERROR    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     flag;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_DRAIN,
        ST_SRC,
        ST_PUSH,
        ST_FINAL
    } state_t;

endpackage

`default_nettype wire

// ----- design/gis_cell.sv -----
// One slot of the sorted message queue: insert by compare, shift on pop.
`default_nettype none

module gis_cell #(
    parameter int VERTEX_BITS = 32
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire gis_pkg::cell_cmd_t cmd,
    input  wire  [VERTEX_BITS-1:0]  key_dest,
    input  wire                     left_valid,
    input  wire  [VERTEX_BITS-1:0]  left_dest,
    input  wire                     left_flag,
    input  wire                     left_gt,
    input  wire                     right_valid,
    input  wire  [VERTEX_BITS-1:0]  right_dest,
    input  wire                     right_flag,
    output logic                    valid,
    output logic [VERTEX_BITS-1:0]  dest,
    output logic                    flag,
    output logic                    gt
);

    logic                   valid_reg, valid_next;
    logic [VERTEX_BITS-1:0] dest_reg, dest_next;
    logic                   flag_reg, flag_next;

    // An empty slot sorts above every key
    assign gt = !valid_reg || (dest_reg > key_dest);

    always_comb
    begin
        valid_next = valid_reg;
        dest_next  = dest_reg;
        flag_next  = flag_reg;
        case (cmd.op)
            gis_pkg::CELL_PUSH:
            begin
                if (gt)
                begin
                    if (left_gt)
                    begin
                        valid_next = left_valid;
                        dest_next  = left_dest;
                        flag_next  = left_flag;
                    end
                    else
                    begin
                        valid_next = 1'b1;
                        dest_next  = key_dest;
                        flag_next  = cmd.flag;
                    end
                end
            end
            gis_pkg::CELL_POP:
            begin
                valid_next = right_valid;
                dest_next  = right_dest;
                flag_next  = right_flag;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dest_reg <= dest_next;
        flag_reg <= flag_next;
    end

    assign valid = valid_reg;
    assign dest  = dest_reg;
    assign flag  = flag_reg;

endmodule

`default_nettype wire

// ----- design/gis_ctrl.sv -----
// Sequencer: edge checks, pop and push control, result hold and output registers.
`default_nettype none

module gis_ctrl #(
    parameter int VERTEX_BITS = 32
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     item_valid,
    output logic                    item_ready,
    input  wire                     opcode,
    input  wire  [31:0]             endpoint_a,
    input  wire  [31:0]             endpoint_b,
    output logic                    result_valid,
    input  wire                     result_ready,
    output logic [1:0]              status,
    output logic [31:0]             vertex,
    output logic                    last,
    input  wire                     head_valid,
    input  wire  [VERTEX_BITS-1:0]  head_dest,
    input  wire                     head_flag,
    input  wire                     full,
    output gis_pkg::cell_cmd_t      cmd,
    output logic [VERTEX_BITS-1:0]  key_dest
);

    gis_pkg::state_t        state_reg, state_next;
    logic [VERTEX_BITS-1:0] lo_reg, lo_next;
    logic [VERTEX_BITS-1:0] hi_reg, hi_next;
    logic                   grp_active_reg, grp_active_next;
    logic [VERTEX_BITS-1:0] grp_dest_reg, grp_dest_next;
    logic                   grp_any_reg, grp_any_next;
    logic [VERTEX_BITS-1:0] cur_src_reg, cur_src_next;
    logic                   group_active_reg, group_active_next;
    logic                   src_in_set_reg, src_in_set_next;
    logic                   hold_valid_reg, hold_valid_next;
    gis_pkg::status_t       hold_status_reg, hold_status_next;
    logic [VERTEX_BITS-1:0] hold_vertex_reg, hold_vertex_next;
    logic                   out_valid_reg, out_valid_next;
    gis_pkg::status_t       out_status_reg, out_status_next;
    logic [VERTEX_BITS-1:0] out_vertex_reg, out_vertex_next;
    logic                   out_last_reg, out_last_next;

    logic                   emit_req;
    gis_pkg::status_t       emit_status;
    logic [VERTEX_BITS-1:0] emit_vertex;
    logic                   flush_req;
    logic                   out_free;
    logic                   emit_ok;
    logic [VERTEX_BITS-1:0] a_m, b_m, a_lo, a_hi;
    logic                   edge_err, new_src, drain, joined;

    assign out_free = !out_valid_reg || result_ready;
    assign emit_ok  = !hold_valid_reg || out_free;

    assign a_m      = endpoint_a[VERTEX_BITS-1:0];
    assign b_m      = endpoint_b[VERTEX_BITS-1:0];
    assign a_lo     = (a_m < b_m) ? a_m : b_m;
    assign a_hi     = (a_m < b_m) ? b_m : a_m;
    assign edge_err = (a_lo == a_hi) || (group_active_reg && (a_lo < cur_src_reg));
    assign new_src  = !group_active_reg || (a_lo != cur_src_reg);
    assign drain    = (state_reg == gis_pkg::ST_DRAIN);
    assign joined   = !grp_any_reg;

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        grp_active_next   = grp_active_reg;
        grp_dest_next     = grp_dest_reg;
        grp_any_next      = grp_any_reg;
        cur_src_next      = cur_src_reg;
        group_active_next = group_active_reg;
        src_in_set_next   = src_in_set_reg;
        item_ready        = 1'b0;
        cmd.op            = gis_pkg::CELL_HOLD;
        cmd.flag          = src_in_set_reg;
        key_dest          = hi_reg;
        emit_req          = 1'b0;
        emit_status       = gis_pkg::STATUS_JOIN;
        emit_vertex       = grp_dest_reg;
        flush_req         = 1'b0;
        case (state_reg)
            gis_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    lo_next         = a_lo;
                    hi_next         = a_hi;
                    grp_active_next = 1'b0;
                    if (opcode)
                    begin
                        state_next = gis_pkg::ST_DRAIN;
                    end
                    else if (edge_err)
                    begin
                        emit_req    = 1'b1;
                        emit_status = gis_pkg::STATUS_ERROR;
                        emit_vertex = a_lo;
                        state_next  = gis_pkg::ST_FINAL;
                    end
                    else if (new_src)
                    begin
                        state_next = gis_pkg::ST_POP;
                    end
                    else
                    begin
                        state_next = gis_pkg::ST_PUSH;
                    end
                end
            end
            gis_pkg::ST_POP, gis_pkg::ST_DRAIN:
            begin
                if (grp_active_reg)
                begin
                    if (head_valid && (head_dest == grp_dest_reg))
                    begin
                        cmd.op       = gis_pkg::CELL_POP;
                        grp_any_next = grp_any_reg | head_flag;
                    end
                    else
                    begin
                        // Destination done: it joins unless a flagged message reached it
                        emit_req = joined;
                        if (!joined || emit_ok)
                        begin
                            grp_active_next = 1'b0;
                        end
                    end
                end
                else if (head_valid && (drain || (head_dest < lo_reg)))
                begin
                    cmd.op          = gis_pkg::CELL_POP;
                    grp_active_next = 1'b1;
                    grp_dest_next   = head_dest;
                    grp_any_next    = head_flag;
                end
                else if (drain)
                begin
                    cur_src_next      = '0;
                    group_active_next = 1'b0;
                    src_in_set_next   = 1'b0;
                    state_next        = gis_pkg::ST_FINAL;
                end
                else
                begin
                    grp_any_next = 1'b0;
                    state_next   = gis_pkg::ST_SRC;
                end
            end
            gis_pkg::ST_SRC:
            begin
                if (head_valid && (head_dest == lo_reg))
                begin
                    cmd.op       = gis_pkg::CELL_POP;
                    grp_any_next = grp_any_reg | head_flag;
                end
                else
                begin
                    emit_req    = joined;
                    emit_vertex = lo_reg;
                    if (!joined || emit_ok)
                    begin
                        src_in_set_next   = joined;
                        cur_src_next      = lo_reg;
                        group_active_next = 1'b1;
                        state_next        = gis_pkg::ST_PUSH;
                    end
                end
            end
            gis_pkg::ST_PUSH:
            begin
                if (!full)
                begin
                    cmd.op     = gis_pkg::CELL_PUSH;
                    state_next = hold_valid_reg ? gis_pkg::ST_FINAL : gis_pkg::ST_IDLE;
                end
                else
                begin
                    emit_req    = 1'b1;
                    emit_status = gis_pkg::STATUS_OVERFLOW;
                    emit_vertex = hi_reg;
                    if (emit_ok)
                    begin
                        state_next = gis_pkg::ST_FINAL;
                    end
                end
            end
            gis_pkg::ST_FINAL:
            begin
                if (hold_valid_reg)
                begin
                    flush_req = 1'b1;
                    if (out_free)
                    begin
                        state_next = gis_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = gis_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gis_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold one result back so the final one of a request can carry last
    always_comb
    begin
        hold_valid_next  = hold_valid_reg;
        hold_status_next = hold_status_reg;
        hold_vertex_next = hold_vertex_reg;
        out_valid_next   = out_valid_reg && !result_ready;
        out_status_next  = out_status_reg;
        out_vertex_next  = out_vertex_reg;
        out_last_next    = out_last_reg;
        if (emit_req && emit_ok)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_status_next = hold_status_reg;
                out_vertex_next = hold_vertex_reg;
                out_last_next   = 1'b0;
            end
            hold_valid_next  = 1'b1;
            hold_status_next = emit_status;
            hold_vertex_next = emit_vertex;
        end
        else if (flush_req && out_free)
        begin
            out_valid_next  = 1'b1;
            out_status_next = hold_status_reg;
            out_vertex_next = hold_vertex_reg;
            out_last_next   = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= gis_pkg::ST_IDLE;
            grp_active_reg   <= 1'b0;
            cur_src_reg      <= '0;
            group_active_reg <= 1'b0;
            src_in_set_reg   <= 1'b0;
            hold_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            grp_active_reg   <= grp_active_next;
            cur_src_reg      <= cur_src_next;
            group_active_reg <= group_active_next;
            src_in_set_reg   <= src_in_set_next;
            hold_valid_reg   <= hold_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        grp_dest_reg    <= grp_dest_next;
        grp_any_reg     <= grp_any_next;
        hold_status_reg <= hold_status_next;
        hold_vertex_reg <= hold_vertex_next;
        out_status_reg  <= out_status_next;
        out_vertex_reg  <= out_vertex_next;
        out_last_reg    <= out_last_next;
    end

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign vertex       = 32'(out_vertex_reg);
    assign last         = out_last_reg;

`ifndef SYNTH
    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> !hold_valid_reg)
        else $error("request accepted while a result is still held");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == gis_pkg::CELL_POP) |-> head_valid)
        else $error("pop from an empty queue");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == gis_pkg::CELL_PUSH) |-> !full)
        else $error("push into a full queue");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == gis_pkg::STATUS_ERROR)) |-> out_last_reg)
        else $error("rejected edge result not marked last");

    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == gis_pkg::ST_DRAIN) && (state_next == gis_pkg::ST_FINAL))
            |=> !head_valid && !group_active_reg)
        else $error("queue not empty after drain");
`endif

endmodule

`default_nettype wire

// ----- design/greedy_independent_set_stream_top.sv -----
// Top level: sequencer plus a chain of sorted message queue cells.
//
//   channel | handshake                   | payload
//   --------+-----------------------------+------------------------------
//   item    | item_valid / item_ready     | opcode, endpoint_a, endpoint_b
//   result  | result_valid / result_ready | status, vertex, last
//
// An edge of the current source is pushed; a rejected edge or an overflow ends the request.
// A new source first pops the messages to each destination below it, one destination at a time,
// then pops the messages to itself, and hands over its last result when it gives any.
// A finish pops every queued message, one destination at a time, then hands over the last result.
// Reset clears the control state and the cell valid bits at once; no clearing pass.
// The sequencer waits while a result is held and the output register is not taken.
`default_nettype none

module greedy_independent_set_stream_top #(
    parameter int QUEUE_DEPTH = 32,
    parameter int VERTEX_BITS = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         item_valid,
    output logic        item_ready,
    input  wire         opcode,
    input  wire  [31:0] endpoint_a,
    input  wire  [31:0] endpoint_b,
    output logic        result_valid,
    input  wire         result_ready,
    output logic [1:0]  status,
    output logic [31:0] vertex,
    output logic        last
);

    gis_pkg::cell_cmd_t     cmd;
    logic [VERTEX_BITS-1:0] key_dest;

    // Queue contents, kept sorted ascending; cell 0 holds the smallest destination
    logic                   c_valid [QUEUE_DEPTH];
    logic [VERTEX_BITS-1:0] c_dest  [QUEUE_DEPTH];
    logic                   c_flag  [QUEUE_DEPTH];
    logic                   c_gt    [QUEUE_DEPTH];

    gis_ctrl #(
        .VERTEX_BITS (VERTEX_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .opcode       (opcode),
        .endpoint_a   (endpoint_a),
        .endpoint_b   (endpoint_b),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .vertex       (vertex),
        .last         (last),
        .head_valid   (c_valid[0]),
        .head_dest    (c_dest[0]),
        .head_flag    (c_flag[0]),
        .full         (c_valid[QUEUE_DEPTH-1]),
        .cmd          (cmd),
        .key_dest     (key_dest)
    );

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic                   l_valid, l_flag, l_gt;
            logic [VERTEX_BITS-1:0] l_dest;
            logic                   r_valid, r_flag;
            logic [VERTEX_BITS-1:0] r_dest;

            // Left neighbor feeds inserts; the head cell takes the new key instead
            if (i == 0)
            begin : g_head
                assign l_valid = 1'b0;
                assign l_dest  = '0;
                assign l_flag  = 1'b0;
                assign l_gt    = 1'b0;
            end
            else
            begin : g_left
                assign l_valid = c_valid[i-1];
                assign l_dest  = c_dest[i-1];
                assign l_flag  = c_flag[i-1];
                assign l_gt    = c_gt[i-1];
            end

            // Right neighbor feeds pops; the tail cell goes empty
            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign r_valid = 1'b0;
                assign r_dest  = '0;
                assign r_flag  = 1'b0;
            end
            else
            begin : g_right
                assign r_valid = c_valid[i+1];
                assign r_dest  = c_dest[i+1];
                assign r_flag  = c_flag[i+1];
            end

            gis_cell #(
                .VERTEX_BITS (VERTEX_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .key_dest    (key_dest),
                .left_valid  (l_valid),
                .left_dest   (l_dest),
                .left_flag   (l_flag),
                .left_gt     (l_gt),
                .right_valid (r_valid),
                .right_dest  (r_dest),
                .right_flag  (r_flag),
                .valid       (c_valid[i]),
                .dest        (c_dest[i]),
                .flag        (c_flag[i]),
                .gt          (c_gt[i])
            );
        end
    endgenerate

endmodule

`default_nettype wire
